### design/tlvp_pkg.sv
// tlvp_pkg: shared types and constants of the tlv record parser
// result item layout, status and kind codes, push bundle between parser and queue
// no dependencies
package tlvp_pkg;

   localparam int unsigned COUNT_W = 12;
   localparam int unsigned FIELD_W = 16;
   localparam logic [COUNT_W-1:0] MAX_RECORDS_RESET = 12'd16;

   localparam logic KIND_RECORD  = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_TOO_MANY = 2'd1;
   localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

   typedef struct packed {
      logic               kind;
      logic [FIELD_W-1:0] record_tag;
      logic [FIELD_W-1:0] value_length;
      logic [FIELD_W-1:0] value_offset;
      logic [COUNT_W-1:0] record_count;
      logic [1:0]         status;
      logic               last_result;
   } rsp_type;

   typedef struct packed {
      logic    desc_vld;
      logic    sum_vld;
      rsp_type desc;
      rsp_type sum;
   } push_type;

endpackage

### design/tlvp_req_if.sv
// tlvp_req_if: byte channel into the tlv record parser
// valid/ready handshake with one message byte and end marks per item
// no dependencies
interface tlvp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;
   logic       end_only;

   modport source (output valid, output data_byte, output last_byte, output end_only,
                   input ready);
   modport sink (input valid, input data_byte, input last_byte, input end_only,
                 output ready);
endinterface

### design/tlvp_rsp_if.sv
// tlvp_rsp_if: result channel out of the tlv record parser
// valid/ready handshake carrying a record descriptor or a message summary
// no dependencies
interface tlvp_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [15:0] record_tag;
   logic [15:0] value_length;
   logic [15:0] value_offset;
   logic [11:0] record_count;
   logic [1:0]  status;
   logic        last_result;

   modport source (output valid, output kind, output record_tag, output value_length,
                   output value_offset, output record_count, output status,
                   output last_result, input ready);
   modport sink (input valid, input kind, input record_tag, input value_length,
                 input value_offset, input record_count, input status,
                 input last_result, output ready);
endinterface

### design/tlvp_parse.sv
// tlvp_parse: per-message parse state and the byte step logic
// turns one accepted item into up to two result items for the queue
// depends on tlvp_pkg
module tlvp_parse #(
   parameter int unsigned MAX_MESSAGE_BYTES = 65536
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [tlvp_pkg::COUNT_W-1:0]  csr_wdata,
   input  logic                          take,
   input  logic [7:0]                    data_byte,
   input  logic                          last_byte,
   input  logic                          end_only,
   output tlvp_pkg::push_type            push
);

   localparam int unsigned POS_W = $clog2(MAX_MESSAGE_BYTES + 1);
   localparam int unsigned OFF_W = (POS_W > 17) ? POS_W : 17;
   localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_MESSAGE_BYTES);

   typedef enum logic [2:0] {
      PH_TAG_LO,
      PH_TAG_HI,
      PH_LEN_LO,
      PH_LEN_HI,
      PH_VALUE
   } phase_type;

   phase_type                        phase_ff, phase_in;
   logic [15:0]                      tag_ff, tag_in;
   logic [15:0]                      len_ff, len_in;
   logic [15:0]                      rem_ff, rem_in;
   logic [POS_W-1:0]                 pos_ff, pos_in;
   logic [tlvp_pkg::COUNT_W-1:0]     rec_ff, rec_in;
   logic                             lim_ff, lim_in;
   logic                             ovf_ff, ovf_in;
   logic [tlvp_pkg::COUNT_W-1:0]     max_ff;

   logic                             fin;
   logic                             lim_sum;
   logic [15:0]                      rem_dec;
   logic [OFF_W-1:0]                 offset;

   always_comb begin
      phase_in = phase_ff;
      tag_in   = tag_ff;
      len_in   = len_ff;
      rem_in   = rem_ff;
      pos_in   = pos_ff;
      rec_in   = rec_ff;
      lim_in   = lim_ff;
      ovf_in   = ovf_ff;
      fin      = 1'b0;
      rem_dec  = rem_ff;
      lim_sum  = 1'b0;
      push     = '0;

      if (take && !end_only) begin
         if (pos_ff == POS_MAX) begin
            ovf_in = 1'b1;
         end else begin
            pos_in = pos_ff + 1'b1;
            unique case (phase_ff)
               PH_TAG_LO: begin
                  tag_in   = {8'd0, data_byte};
                  phase_in = PH_TAG_HI;
               end
               PH_TAG_HI: begin
                  tag_in   = {data_byte, tag_ff[7:0]};
                  phase_in = PH_LEN_LO;
               end
               PH_LEN_LO: begin
                  len_in   = {8'd0, data_byte};
                  phase_in = PH_LEN_HI;
               end
               PH_LEN_HI: begin
                  len_in = {data_byte, len_ff[7:0]};
                  if ({data_byte, len_ff[7:0]} == 16'd0) begin
                     fin = 1'b1;
                  end else begin
                     rem_in   = {data_byte, len_ff[7:0]};
                     phase_in = PH_VALUE;
                  end
               end
               PH_VALUE: begin
                  if (rem_ff != 16'd0) begin
                     rem_dec = rem_ff - 1'b1;
                  end
                  rem_in = rem_dec;
                  if (rem_dec == 16'd0) begin
                     fin = 1'b1;
                  end
               end
               default: begin
                  phase_in = PH_TAG_LO;
               end
            endcase
         end
      end

      // pos_ff is the position of the record's final byte
      offset = OFF_W'(pos_ff) + 1'b1 - OFF_W'(len_in);

      if (fin) begin
         phase_in = PH_TAG_LO;
         rem_in   = 16'd0;
         if (|offset[OFF_W-1:16]) begin
            ovf_in = 1'b1;
         end else if (rec_ff >= max_ff) begin
            lim_in = 1'b1;
         end else begin
            rec_in                    = rec_ff + 1'b1;
            push.desc_vld             = 1'b1;
            push.desc.kind            = tlvp_pkg::KIND_RECORD;
            push.desc.record_tag      = tag_in;
            push.desc.value_length    = len_in;
            push.desc.value_offset    = offset[15:0];
         end
      end

      if (take && (last_byte || end_only)) begin
         lim_sum                = lim_in || (rec_in >= max_ff);
         push.sum_vld           = 1'b1;
         push.sum.kind          = tlvp_pkg::KIND_SUMMARY;
         push.sum.record_count  = rec_in;
         push.sum.last_result   = 1'b1;
         if (lim_sum) begin
            push.sum.status = tlvp_pkg::STATUS_TOO_MANY;
         end else if (ovf_in) begin
            push.sum.status = tlvp_pkg::STATUS_TOO_LONG;
         end else begin
            push.sum.status = tlvp_pkg::STATUS_OK;
         end
         phase_in = PH_TAG_LO;
         tag_in   = 16'd0;
         len_in   = 16'd0;
         rem_in   = 16'd0;
         pos_in   = '0;
         rec_in   = '0;
         lim_in   = 1'b0;
         ovf_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TAG_LO;
         tag_ff   <= 16'd0;
         len_ff   <= 16'd0;
         rem_ff   <= 16'd0;
         pos_ff   <= '0;
         rec_ff   <= '0;
         lim_ff   <= 1'b0;
         ovf_ff   <= 1'b0;
         max_ff   <= tlvp_pkg::MAX_RECORDS_RESET;
      end else begin
         phase_ff <= phase_in;
         tag_ff   <= tag_in;
         len_ff   <= len_in;
         rem_ff   <= rem_in;
         pos_ff   <= pos_in;
         rec_ff   <= rec_in;
         lim_ff   <= lim_in;
         ovf_ff   <= ovf_in;
         if (csr_we) begin
            max_ff <= csr_wdata;
         end
      end
   end

   a_value_has_bytes: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_VALUE) |-> (rem_ff != 16'd0))
      else $error("value phase with no bytes remaining");

   a_summary_clears: assert property (@(posedge clock) disable iff (reset)
      push.sum_vld |=> (pos_ff == '0) && (rec_ff == '0) && (phase_ff == PH_TAG_LO))
      else $error("message state not cleared after summary");

endmodule

### design/tlvp_rsp_queue.sv
// tlvp_rsp_queue: three-entry result queue, up to two items pushed per cycle
// head entry drives the result channel; depends on tlvp_pkg
module tlvp_rsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  tlvp_pkg::push_type  push,
   input  logic                pop_ready,
   output logic                room,
   output logic                head_vld,
   output tlvp_pkg::rsp_type   head
);

   localparam int unsigned DEPTH = 3;

   tlvp_pkg::rsp_type q_ff [DEPTH];
   tlvp_pkg::rsp_type q_in [DEPTH];
   logic [1:0]        cnt_ff, cnt_in;
   logic [1:0]        base;
   logic              pop;
   logic              p0v, p1v;
   tlvp_pkg::rsp_type p0;

   assign pop      = (cnt_ff != 2'd0) && pop_ready;
   assign head_vld = (cnt_ff != 2'd0);
   assign head     = q_ff[0];
   assign room     = (cnt_ff <= 2'd1);

   assign p0v = push.desc_vld || push.sum_vld;
   assign p1v = push.desc_vld && push.sum_vld;
   assign p0  = push.desc_vld ? push.desc : push.sum;

   always_comb begin
      base = cnt_ff - {1'b0, pop};
      for (int i = 0; i < DEPTH; i++) begin
         if (pop && (i < DEPTH - 1)) begin
            q_in[i] = q_ff[i+1];
         end else begin
            q_in[i] = q_ff[i];
         end
         if (p0v && (base == 2'(i))) begin
            q_in[i] = p0;
         end
         if (p1v && ((base + 2'd1) == 2'(i))) begin
            q_in[i] = push.sum;
         end
      end
      cnt_in = base + {1'b0, p0v} + {1'b0, p1v};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      for (int i = 0; i < DEPTH; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      (pop && !p0v) |=> (cnt_ff == $past(cnt_ff) - 2'd1))
      else $error("queue count did not drop on pop");

   a_head_holds: assert property (@(posedge clock) disable iff (reset)
      (head_vld && !pop) |=> (q_ff[0] == $past(q_ff[0])))
      else $error("waiting head entry changed");

endmodule

### design/tlv_record_parser_core.sv
// tlv_record_parser_core: top level of the tlv record parser
// depends on tlvp_pkg, tlvp_req_if, tlvp_rsp_if, tlvp_parse, tlvp_rsp_queue
//
// usage
//   req_chan takes one message byte per item (data_byte), with last_byte marking
//   the final byte, or end_only marking an item that carries no byte and only
//   ends the message. rsp_chan returns record descriptors (tag, length, offset of
//   the first value byte) as each record completes, and one summary item with the
//   record count and status at each message end.
//   csr_we/csr_wdata write max_records; write only while the block is idle.
// throughput
//   one item is accepted per cycle while ready is high; its results are registered in
//   the queue and reach rsp_chan behind any waiting results. an item ending a record
//   and the message yields two results, which leave in turn. ready is high while the
//   three-entry result queue holds at most one item; the queue alone limits rate.
// reset
//   reset clears the parse state and the queue, and sets max_records to 16.
// stall
//   when rsp_chan.ready is low, results wait in the queue; req_chan.ready drops
//   once two results are waiting, and nothing is lost or reordered.
module tlv_record_parser_core #(
   parameter int unsigned MAX_MESSAGE_BYTES = 65536
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [11:0]          csr_wdata,
   tlvp_req_if.sink             req_chan,
   tlvp_rsp_if.source           rsp_chan
);

   logic               room;
   logic               take;
   logic               head_vld;
   tlvp_pkg::push_type push;
   tlvp_pkg::rsp_type  head;

   assign req_chan.ready = room && !reset;
   assign take           = req_chan.valid && room && !reset;

   tlvp_parse #(
      .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .take      (take),
      .data_byte (req_chan.data_byte),
      .last_byte (req_chan.last_byte),
      .end_only  (req_chan.end_only),
      .push      (push)
   );

   tlvp_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop_ready (rsp_chan.ready),
      .room      (room),
      .head_vld  (head_vld),
      .head      (head)
   );

   assign rsp_chan.valid        = head_vld;
   assign rsp_chan.kind         = head.kind;
   assign rsp_chan.record_tag   = head.record_tag;
   assign rsp_chan.value_length = head.value_length;
   assign rsp_chan.value_offset = head.value_offset;
   assign rsp_chan.record_count = head.record_count;
   assign rsp_chan.status       = head.status;
   assign rsp_chan.last_result  = head.last_result;

endmodule

### bench/tlv_record_parser_core_test.sv
// tlv_record_parser_core_test: self-checking bench for the tlv record parser top level
// directed table then random messages, each result checked against a cycle-free parse predictor
// depends on tlvp_pkg, tlvp_req_if, tlvp_rsp_if and tlv_record_parser_core
`timescale 1ns / 1ps

module tlv_record_parser_core_test;

   localparam int unsigned MSG_BYTES = 65536;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_ITEMS = 170;
   localparam tlvp_pkg::rsp_type NO_RESULT = '0;

   typedef enum logic [2:0] {
      PH_TAG_LO, PH_TAG_HI, PH_LEN_LO, PH_LEN_HI, PH_VALUE
   } hdr_phase_type;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type      kind;
      logic [7:0]        data;
      logic              last;
      logic              eonly;
      logic [11:0]       cfg;
      logic              typed;
      tlvp_pkg::rsp_type want;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [11:0] csr_wdata;

   tlvp_req_if req_bus ();
   tlvp_rsp_if rsp_bus ();

   tlv_record_parser_core #(
      .MAX_MESSAGE_BYTES(MSG_BYTES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus)
   );

   // parse state of the predictor
   hdr_phase_type hdr_phase;
   logic [15:0]   tag_acc;
   logic [15:0]   len_acc;
   logic [15:0]   value_left;
   logic [16:0]   msg_pos;
   logic [11:0]   rec_count;
   logic [11:0]   cap_limit;
   logic          cap_hit;
   logic          too_long;

   tlvp_pkg::rsp_type pending_results [$];

   int errors = 0;
   int items_sent = 0;
   int messages = 0;
   int descs_seen = 0;
   int sums_seen = 0;
   int cap_writes = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   int send_idle_by_mode [4] = '{0, 84, 0, 7};
   int recv_stall_by_mode [4] = '{0, 0, 84, 7};
   logic [11:0] phase_caps [8] = '{12'd16, 12'd0, 12'd3, 12'd4095, 12'd1, 12'd2, 12'd4095, 12'd5};

   stim_row_type directed_rows [27] = '{
      '{ROW_ITEM, 8'h00, 1'b0, 1'b1, 12'd0, 1'b1,
        {tlvp_pkg::KIND_SUMMARY, 48'd0, 12'd0, tlvp_pkg::STATUS_OK, 1'b1}},
      '{ROW_ITEM, 8'hFF, 1'b0, 1'b0, 12'd0, 1'b0, NO_RESULT},
      '{ROW_ITEM, 8'hFF, 1'b0, 1'b0, 12'd0, 1'b0, NO_RESULT},
      '{ROW_ITEM, 8'h00, 1'b0, 1'b0, 12'd0, 1'b0, NO_RESULT},
      '{ROW_ITEM, 8'h00, 1'b0, 1'b0, 12'd0, 1'b1,
        {tlvp_pkg::KIND_RECORD, 16'hFFFF, 16'd0, 16'd4, 12'd0, tlvp_pkg::STATUS_OK, 1'b0}},
      '{ROW_ITEM, 8'h00, 1'b0, 1'b0, 12'd0, 1'b0, NO_RESULT},
      '{ROW_ITEM, 8'h00, 1'b0, 1'b0, 12'd0, 1'b0, NO_RESULT},
      '{ROW_ITEM, 8'h01, 1'b0, 1'b0, 12'd0, 1'b0, NO_RESULT},
      '{ROW_ITEM, 8'h00, 1'b0, 1'b0, 12'd0, 1'b0, NO_RESULT},
      '{ROW_ITEM, 8'hAA, 1'b1, 1'b0, 12'd0, 1'b1,
        {tlvp_pkg::KIND_SUMMARY, 48'd0, 12'd2, tlvp_pkg::STATUS_OK, 1'b1}},
      '{ROW_ITEM, 8'h12, 1'b0, 1'b0, 12'd0, 1'b0, NO_RESULT},
      '{ROW_ITEM, 8'h34, 1'b0, 1'b0, 12'd0, 1'b0, NO_RESULT},
      '{ROW_ITEM, 8'h02, 1'b0, 1'b0, 12'd0, 1'b0, NO_RESULT},
      '{ROW_ITEM, 8'h00, 1'b0, 1'b0, 12'd0, 1'b0, NO_RESULT},
      '{ROW_ITEM, 8'hA5, 1'b1, 1'b1, 12'd0, 1'b1,
        {tlvp_pkg::KIND_SUMMARY, 48'd0, 12'd0, tlvp_pkg::STATUS_OK, 1'b1}},
      '{ROW_CSR, 8'h00, 1'b0, 1'b0, 12'd0, 1'b0, NO_RESULT},
      '{ROW_ITEM, 8'h5A, 1'b0, 1'b1, 12'd0, 1'b1,
        {tlvp_pkg::KIND_SUMMARY, 48'd0, 12'd0, tlvp_pkg::STATUS_TOO_MANY, 1'b1}},
      '{ROW_CSR, 8'h00, 1'b0, 1'b0, 12'd1, 1'b0, NO_RESULT},
      '{ROW_ITEM, 8'h34, 1'b0, 1'b0, 12'd0, 1'b0, NO_RESULT},
      '{ROW_ITEM, 8'h12, 1'b0, 1'b0, 12'd0, 1'b0, NO_RESULT},
      '{ROW_ITEM, 8'h00, 1'b0, 1'b0, 12'd0, 1'b0, NO_RESULT},
      '{ROW_ITEM, 8'h00, 1'b0, 1'b0, 12'd0, 1'b1,
        {tlvp_pkg::KIND_RECORD, 16'h1234, 16'd0, 16'd4, 12'd0, tlvp_pkg::STATUS_OK, 1'b0}},
      '{ROW_ITEM, 8'h78, 1'b0, 1'b0, 12'd0, 1'b0, NO_RESULT},
      '{ROW_ITEM, 8'h56, 1'b0, 1'b0, 12'd0, 1'b0, NO_RESULT},
      '{ROW_ITEM, 8'h00, 1'b0, 1'b0, 12'd0, 1'b0, NO_RESULT},
      '{ROW_ITEM, 8'h00, 1'b1, 1'b0, 12'd0, 1'b1,
        {tlvp_pkg::KIND_SUMMARY, 48'd0, 12'd1, tlvp_pkg::STATUS_TOO_MANY, 1'b1}},
      '{ROW_CSR, 8'h00, 1'b0, 1'b0, 12'd4095, 1'b0, NO_RESULT}
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("[tlv_record_parser_core] ERROR");
      $finish;
   end

   function automatic void clear_message();
      hdr_phase = PH_TAG_LO;
      tag_acc = '0;
      len_acc = '0;
      value_left = '0;
      msg_pos = '0;
      rec_count = '0;
      cap_hit = 1'b0;
      too_long = 1'b0;
   endfunction

   function automatic void close_record(logic [16:0] pos);
      int offs;
      tlvp_pkg::rsp_type r;
      offs = int'(pos) + 1 - int'(len_acc);
      hdr_phase = PH_TAG_LO;
      value_left = '0;
      if (offs > 65535) begin
         too_long = 1'b1;
      end else if (rec_count >= cap_limit) begin
         cap_hit = 1'b1;
      end else begin
         rec_count = rec_count + 12'd1;
         r = '0;
         r.kind = tlvp_pkg::KIND_RECORD;
         r.record_tag = tag_acc;
         r.value_length = len_acc;
         r.value_offset = offs[15:0];
         pending_results.push_back(r);
      end
   endfunction

   function automatic void tlv_parse_step(logic [7:0] d, logic l, logic e);
      logic [16:0] pos;
      tlvp_pkg::rsp_type r;
      if (!e) begin
         if (msg_pos >= MSG_BYTES) begin
            too_long = 1'b1;
         end else begin
            pos = msg_pos;
            msg_pos = pos + 17'd1;
            case (hdr_phase)
               PH_TAG_LO: begin
                  tag_acc = {8'h00, d};
                  hdr_phase = PH_TAG_HI;
               end
               PH_TAG_HI: begin
                  tag_acc[15:8] = d;
                  hdr_phase = PH_LEN_LO;
               end
               PH_LEN_LO: begin
                  len_acc = {8'h00, d};
                  hdr_phase = PH_LEN_HI;
               end
               PH_LEN_HI: begin
                  len_acc[15:8] = d;
                  if (len_acc == 16'd0) begin
                     close_record(pos);
                  end else begin
                     value_left = len_acc;
                     hdr_phase = PH_VALUE;
                  end
               end
               default: begin
                  if (value_left != 16'd0) value_left = value_left - 16'd1;
                  if (value_left == 16'd0) close_record(pos);
               end
            endcase
         end
      end
      if (l || e) begin
         if (rec_count >= cap_limit) cap_hit = 1'b1;
         r = '0;
         r.kind = tlvp_pkg::KIND_SUMMARY;
         r.record_count = rec_count;
         if (cap_hit) begin
            r.status = tlvp_pkg::STATUS_TOO_MANY;
         end else if (too_long) begin
            r.status = tlvp_pkg::STATUS_TOO_LONG;
         end else begin
            r.status = tlvp_pkg::STATUS_OK;
         end
         r.last_result = 1'b1;
         pending_results.push_back(r);
         clear_message();
      end
   endfunction

   function automatic void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      tlvp_pkg::rsp_type got;
      tlvp_pkg::rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = {rsp_bus.kind, rsp_bus.record_tag, rsp_bus.value_length, rsp_bus.value_offset,
                rsp_bus.record_count, rsp_bus.status, rsp_bus.last_result};
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual 0x%016h", $time, got);
         end else begin
            want = pending_results.pop_front();
            compare_field("kind", want.kind, got.kind);
            compare_field("record_tag", want.record_tag, got.record_tag);
            compare_field("value_length", want.value_length, got.value_length);
            compare_field("value_offset", want.value_offset, got.value_offset);
            compare_field("record_count", want.record_count, got.record_count);
            compare_field("status", want.status, got.status);
            compare_field("last_result", want.last_result, got.last_result);
            if (want.kind == tlvp_pkg::KIND_SUMMARY) sums_seen++;
            else descs_seen++;
         end
      end
      rsp_bus.ready <= ($urandom_range(1, 100) > recv_stall_pct);
   end

   task automatic send_item(input logic [7:0] d, input logic l, input logic e);
      while ($urandom_range(1, 100) <= send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data_byte <= d;
      req_bus.last_byte <= l;
      req_bus.end_only <= e;
      do @(posedge clock); while (!req_bus.ready);
      tlv_parse_step(d, l, e);
      items_sent++;
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_cap(input logic [11:0] v);
      drain_results();
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      cap_limit = v;
      cap_writes++;
      csr_we <= 1'b0;
   endtask

   function automatic void put_record(ref logic [7:0] q[$], input logic [15:0] tag,
                                      input logic [15:0] vlen, input int nbytes);
      for (int k = 0; k < nbytes; k++) begin
         case (k)
            0: q.push_back(tag[7:0]);
            1: q.push_back(tag[15:8]);
            2: q.push_back(vlen[7:0]);
            3: q.push_back(vlen[15:8]);
            default: q.push_back(8'($urandom));
         endcase
      end
   endfunction

   function automatic logic [15:0] pick_len();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5) return 16'($urandom_range(0, 2));
      else if (r < 9) return 16'($urandom_range(3, 8));
      else return 16'($urandom_range(9, 40));
   endfunction

   task automatic deliver(input logic [7:0] msg[$]);
      logic by_last;
      by_last = (msg.size() != 0) && ($urandom_range(0, 2) != 0);
      foreach (msg[k]) send_item(msg[k], by_last && (k == msg.size() - 1), 1'b0);
      if (!by_last) send_item(8'($urandom), 1'($urandom_range(0, 1)), 1'b1);
      messages++;
   endtask

   task automatic send_message();
      logic [7:0] msg[$];
      int shape;
      logic [15:0] vlen;
      shape = $urandom_range(0, 99);
      if (shape < 90) begin
         repeat ($urandom_range(0, 6)) begin
            vlen = pick_len();
            put_record(msg, 16'($urandom), vlen, 4 + vlen);
         end
         // cut record left hanging at message end
         if (shape >= 80) begin
            vlen = ($urandom_range(0, 3) == 0) ? 16'hFFFF : pick_len() + 16'd1;
            put_record(msg, 16'($urandom), vlen, $urandom_range(1, (vlen > 8) ? 11 : 3 + vlen));
         end
      end else begin
         repeat ($urandom_range(0, 12)) msg.push_back(8'($urandom));
      end
      deliver(msg);
   endtask

   initial begin
      int target;
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_wdata <= '0;
      req_bus.valid <= 1'b0;
      req_bus.data_byte <= '0;
      req_bus.last_byte <= 1'b0;
      req_bus.end_only <= 1'b0;
      clear_message();
      cap_limit = tlvp_pkg::MAX_RECORDS_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            write_cap(directed_rows[i].cfg);
         end else begin
            send_item(directed_rows[i].data, directed_rows[i].last, directed_rows[i].eonly);
            if (directed_rows[i].typed)
               pending_results[pending_results.size() - 1] = directed_rows[i].want;
         end
      end

      for (int p = 0; p < 8; p++) begin
         write_cap(phase_caps[p]);
         send_idle_pct = send_idle_by_mode[p % 4];
         recv_stall_pct = recv_stall_by_mode[p % 4];
         target = items_sent + PHASE_ITEMS;
         while (items_sent < target) send_message();
      end

      drain_results();
      $display("covered %0d items in %0d messages over %0d max_records settings",
               items_sent, messages, cap_writes);
      $display("checked %0d record descriptors and %0d message summaries", descs_seen, sums_seen);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("[tlv_record_parser_core] OK");
      end else begin
         $display("[tlv_record_parser_core] ERROR");
      end
      $finish;
   end

endmodule

### files.f
design/tlvp_pkg.sv
design/tlvp_req_if.sv
design/tlvp_rsp_if.sv
design/tlvp_parse.sv
design/tlvp_rsp_queue.sv
design/tlv_record_parser_core.sv
bench/tlv_record_parser_core_test.sv
